>>> src/ptft_pkg.sv
// ----------------------------------------------------------------------------
// ptft_pkg: shared types and constants of the page table translator
// Address split, table geometry and the packed result record.
// ----------------------------------------------------------------------------
package ptft_pkg;

	localparam int VA_W        = 16;
	localparam int OFFSET_BITS = 8;
	localparam int PAGE_BITS   = 8;
	localparam int FRAME_BITS  = 7;
	localparam int PAGE_COUNT  = 1 << PAGE_BITS;
	localparam int FRAME_COUNT = 1 << FRAME_BITS;
	localparam int PA_W        = FRAME_BITS + OFFSET_BITS;
	localparam int COUNT_W     = 32;

	typedef logic [VA_W-1:0]        vaddr_t;
	typedef logic [PAGE_BITS-1:0]   page_t;
	typedef logic [FRAME_BITS-1:0]  frame_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [COUNT_W-1:0]     count_t;

	// First member is the top bits: physical_address lands in the lowest bits.
	typedef struct packed {
		count_t          fault_count;
		logic            replaced;
		frame_t          load_frame;
		page_t           load_page;
		logic            page_fault;
		logic [PA_W-1:0] physical_address;
	} result_t;

endpackage

>>> src/ptft_ram.sv
// ----------------------------------------------------------------------------
// ptft_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/ptft_xlate.sv
// ----------------------------------------------------------------------------
// ptft_xlate: translation stage with page table and FIFO replacement
// Reads the frame RAM and owner RAM on transfer, decides hit or fault in the
// next cycle and writes the table back when the result moves on.
// ----------------------------------------------------------------------------
module ptft_xlate (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptft_pkg::vaddr_t  in_va,
	output logic              res_valid,
	input  logic              res_ready,
	output ptft_pkg::result_t res
);

	logic                                 valid_s1;
	ptft_pkg::vaddr_t                     va_s1;
	logic                                 tbl_fwd_s1;
	ptft_pkg::frame_t                     tbl_fwd_data_s1;
	logic                                 own_fwd_s1;
	ptft_pkg::page_t                      own_fwd_data_s1;
	logic [ptft_pkg::PAGE_COUNT-1:0]      resident_q;
	logic [ptft_pkg::FRAME_BITS:0]        next_free_q;
	ptft_pkg::frame_t                     victim_q;
	ptft_pkg::count_t                     count_q;

	logic             accept;
	logic             fire_s1;
	ptft_pkg::page_t  page_in;
	ptft_pkg::page_t  page_s1;
	ptft_pkg::offset_t offset_s1;
	ptft_pkg::frame_t tbl_rd;
	ptft_pkg::page_t  own_rd;
	logic             hit;
	logic             fault;
	logic             free_left;
	logic             evict;
	ptft_pkg::frame_t hit_frame;
	ptft_pkg::frame_t frame;
	ptft_pkg::page_t  owner;
	logic             repl;
	ptft_pkg::frame_t victim_d;
	ptft_pkg::count_t count_d;

	assign fire_s1  = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || fire_s1;
	assign accept   = in_valid && in_ready;

	assign page_in   = in_va[ptft_pkg::OFFSET_BITS +: ptft_pkg::PAGE_BITS];
	assign page_s1   = va_s1[ptft_pkg::OFFSET_BITS +: ptft_pkg::PAGE_BITS];
	assign offset_s1 = va_s1[ptft_pkg::OFFSET_BITS-1:0];

	assign hit       = resident_q[page_s1];
	assign fault     = !hit;
	assign free_left = !next_free_q[ptft_pkg::FRAME_BITS];
	assign evict     = fault && !free_left;
	assign hit_frame = tbl_fwd_s1 ? tbl_fwd_data_s1 : tbl_rd;
	assign owner     = own_fwd_s1 ? own_fwd_data_s1 : own_rd;

	always_comb begin
		priority if (hit) begin
			frame = hit_frame;
		end else if (free_left) begin
			frame = next_free_q[ptft_pkg::FRAME_BITS-1:0];
		end else begin
			frame = victim_q;
		end
	end

	// Once all frames are handed out, a frame's owner stays resident in it
	// until that frame is evicted, so the owner's resident bit decides.
	assign repl = evict && resident_q[owner];

	assign victim_d = (fire_s1 && evict) ? victim_q + ptft_pkg::FRAME_BITS'(1) : victim_q;
	assign count_d  = (fault && count_q != '1) ? count_q + ptft_pkg::COUNT_W'(1) : count_q;

	always_comb begin
		res.physical_address = {frame, offset_s1};
		res.page_fault       = fault;
		res.load_page        = fault ? page_s1 : '0;
		res.load_frame       = fault ? frame : '0;
		res.replaced         = repl;
		res.fault_count      = count_d;
	end
	assign res_valid = valid_s1;

	ptft_ram #(
		.WIDTH(ptft_pkg::FRAME_BITS),
		.DEPTH(ptft_pkg::PAGE_COUNT)
	) u_frame_ram (
		.clk   (clk),
		.we    (fire_s1 && fault),
		.waddr (page_s1),
		.wdata (frame),
		.re    (accept),
		.raddr (page_in),
		.rdata (tbl_rd)
	);

	ptft_ram #(
		.WIDTH(ptft_pkg::PAGE_BITS),
		.DEPTH(ptft_pkg::FRAME_COUNT)
	) u_owner_ram (
		.clk   (clk),
		.we    (fire_s1 && fault),
		.waddr (frame),
		.wdata (page_s1),
		.re    (accept),
		.raddr (victim_d),
		.rdata (own_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of stage 1; forward a write that lands on the same edge as the read.
	always_ff @(posedge clk) begin
		if (accept) begin
			va_s1           <= in_va;
			tbl_fwd_s1      <= fire_s1 && fault && (page_s1 == page_in);
			tbl_fwd_data_s1 <= frame;
			own_fwd_s1      <= fire_s1 && fault && (frame == victim_d);
			own_fwd_data_s1 <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_q  <= '0;
			next_free_q <= '0;
			victim_q    <= '0;
			count_q     <= '0;
		end else if (fire_s1) begin
			if (repl) begin
				resident_q[owner] <= 1'b0;
			end
			if (fault) begin
				resident_q[page_s1] <= 1'b1;
			end
			if (fault && free_left) begin
				next_free_q <= next_free_q + (ptft_pkg::FRAME_BITS+1)'(1);
			end
			victim_q <= victim_d;
			count_q  <= count_d;
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= (ptft_pkg::FRAME_BITS+1)'(ptft_pkg::FRAME_COUNT))
		else $error("free frame counter ran past the frame count");

	a_victim_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && fault && free_left) |-> (victim_d == victim_q))
		else $error("victim pointer moved while free frames remain");

	a_evict_owner_resident: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && evict) |-> resident_q[owner])
		else $error("evicted frame has no resident owner");

	a_fault_maps_page: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && fault) |=> resident_q[$past(page_s1)])
		else $error("faulting page not resident after mapping");

endmodule

>>> src/page_table_fifo_translate.sv
// ----------------------------------------------------------------------------
// page_table_fifo_translate: demand-paging translator with FIFO replacement
// An input transfer reaches result valid through the table stage register
// and then the output register. Throughput: one address per cycle unless the
// output stalls, set by the read-modify-write of the frame RAM with write
// forwarding. Reset clears resident bits, free-frame count, victim pointer
// and fault count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_table_fifo_translate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] virtual_address
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [14:0] physical_address, [15] page_fault, [23:16] load_page,
	// [30:24] load_frame, [31] replaced, [63:32] fault_count
	output logic [63:0] m_axis_tdata
);

	logic              res_valid;
	logic              res_ready;
	ptft_pkg::result_t res;
	logic              out_valid_q;
	ptft_pkg::result_t out_data_q;

	ptft_xlate u_xlate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_va     (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Take a new result when the output register is empty or drains this cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for page_table_fifo_translate
// Drives virtual addresses into the stream input and checks every translated
// result against a behavioral page table model, typed directed rows against
// their listed values. The model covers resident hits, faults into free frames
// and FIFO eviction. A directed table runs first; random traffic then mixes
// working sets, uniform addresses and page sweeps. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		ptft_pkg::vaddr_t  va;
		bit                typed;
		ptft_pkg::result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [63:0] m_tdata;

	bit quiet = 1'b0;
	int errors = 0;
	int hits = 0;
	int faults_seen = 0;
	int evictions = 0;
	int idle_cycles = 0;

	// page table model
	bit                page_resident [ptft_pkg::PAGE_COUNT];
	ptft_pkg::frame_t  page_frame    [ptft_pkg::PAGE_COUNT];
	ptft_pkg::page_t   frame_page    [ptft_pkg::FRAME_COUNT];
	int                frames_handed;
	ptft_pkg::frame_t  evict_ptr;
	ptft_pkg::count_t  fault_tally;

	ptft_pkg::result_t translation_q [$];
	stim_row_t         directed_rows [$];

	page_table_fifo_translate uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void translate_address(input ptft_pkg::vaddr_t va,
			output ptft_pkg::result_t r);
		ptft_pkg::page_t   page;
		ptft_pkg::offset_t offset;
		ptft_pkg::frame_t  frame;
		ptft_pkg::page_t   owner;
		logic              fault;
		logic              repl;
		page   = va[ptft_pkg::OFFSET_BITS +: ptft_pkg::PAGE_BITS];
		offset = va[ptft_pkg::OFFSET_BITS-1:0];
		fault  = 1'b0;
		repl   = 1'b0;
		if (page_resident[page]) begin
			frame = page_frame[page];
		end else begin
			fault = 1'b1;
			if (fault_tally != '1)
				fault_tally++;
			if (frames_handed < ptft_pkg::FRAME_COUNT) begin
				frame = ptft_pkg::frame_t'(frames_handed);
				frames_handed++;
			end else begin
				frame = evict_ptr;
				owner = frame_page[frame];
				// invalidate the owner only if it still lives in this frame
				if (page_resident[owner] && page_frame[owner] == frame) begin
					page_resident[owner] = 1'b0;
					repl = 1'b1;
				end
				evict_ptr = frame + ptft_pkg::frame_t'(1);
			end
			page_resident[page] = 1'b1;
			page_frame[page]    = frame;
			frame_page[frame]   = page;
		end
		r.physical_address = {frame, offset};
		r.page_fault       = fault;
		r.load_page        = fault ? page : '0;
		r.load_frame       = fault ? frame : '0;
		r.replaced         = repl;
		r.fault_count      = fault_tally;
	endfunction

	function automatic stim_row_t make_row(input ptft_pkg::vaddr_t va, input bit typed,
			input int pa, input int pf, input int lp, input int lf,
			input int rp, input longint cnt);
		stim_row_t row;
		row.va                      = va;
		row.typed                   = typed;
		row.want.physical_address   = pa[ptft_pkg::PA_W-1:0];
		row.want.page_fault         = pf[0];
		row.want.load_page          = lp[ptft_pkg::PAGE_BITS-1:0];
		row.want.load_frame         = lf[ptft_pkg::FRAME_BITS-1:0];
		row.want.replaced           = rp[0];
		row.want.fault_count        = cnt[ptft_pkg::COUNT_W-1:0];
		return row;
	endfunction

	task automatic send_address(input ptft_pkg::vaddr_t va, input bit typed,
			input ptft_pkg::result_t want);
		ptft_pkg::result_t r;
		while (!quiet && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= va;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// model state always advances; typed rows override the expectation
		translate_address(va, r);
		translation_q.push_back(typed ? want : r);
	endtask

	function automatic void compare_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// result side: random backpressure, check each transfer
	always @(posedge clk) begin
		ptft_pkg::result_t got;
		ptft_pkg::result_t want;
		m_tready <= quiet || ($urandom_range(99) >= 16);
		if (m_tvalid && m_tready) begin
			got = ptft_pkg::result_t'(m_tdata);
			if (translation_q.size() == 0) begin
				errors++;
				$display("%0t mismatch: unexpected result %0h", $time, m_tdata);
			end else begin
				want = translation_q.pop_front();
				compare_field("physical_address", want.physical_address,
					got.physical_address);
				compare_field("page_fault", want.page_fault, got.page_fault);
				compare_field("load_page", want.load_page, got.load_page);
				compare_field("load_frame", want.load_frame, got.load_frame);
				compare_field("replaced", want.replaced, got.replaced);
				compare_field("fault_count", want.fault_count, got.fault_count);
				if (want.page_fault)
					faults_seen++;
				else
					hits++;
				if (want.replaced)
					evictions++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		ptft_pkg::result_t none;
		ptft_pkg::vaddr_t  va;
		ptft_pkg::page_t   ws_base;
		ptft_pkg::page_t   sweep_page;
		int                ws_size;
		int                pick;
		none = '0;
		for (int i = 0; i < ptft_pkg::PAGE_COUNT; i++) begin
			page_resident[i] = 1'b0;
			page_frame[i]    = '0;
		end
		for (int i = 0; i < ptft_pkg::FRAME_COUNT; i++)
			frame_page[i] = '0;
		frames_handed = 0;
		evict_ptr     = '0;
		fault_tally   = '0;

		// first rows follow directly from the empty table after reset
		directed_rows.push_back(make_row(16'hFFFF, 1, 16'h00FF, 1, 8'hFF, 0, 0, 1));
		directed_rows.push_back(make_row(16'h0000, 1, 16'h0100, 1, 8'h00, 1, 0, 2));
		directed_rows.push_back(make_row(16'hFF00, 1, 16'h0000, 0, 0, 0, 0, 2));
		directed_rows.push_back(make_row(16'h00FF, 1, 16'h01FF, 0, 0, 0, 0, 2));
		directed_rows.push_back(make_row(16'hAA55, 1, 16'h0255, 1, 8'hAA, 2, 0, 3));
		directed_rows.push_back(make_row(16'h55AA, 1, 16'h03AA, 1, 8'h55, 3, 0, 4));
		directed_rows.push_back(make_row(16'hAA00, 1, 16'h0200, 0, 0, 0, 0, 4));
		directed_rows.push_back(make_row(16'h8000, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h7FFF, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h0180, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'hFE01, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h0001, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h80FF, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h1234, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h1235, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'hFFFE, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h7F00, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h5555, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'hAAAA, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(16'h0F0F, 0, 0, 0, 0, 0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_address(directed_rows[i].va, directed_rows[i].typed, directed_rows[i].want);

		ws_base    = ptft_pkg::page_t'($urandom);
		ws_size    = 16;
		sweep_page = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 400 && n < 650);
			if (n % 100 == 0) begin
				ws_base = ptft_pkg::page_t'($urandom);
				ws_size = $urandom_range(40, 4);
			end
			pick = $urandom_range(99);
			va   = ptft_pkg::vaddr_t'($urandom);
			if (pick < 55) begin
				// locality: mostly hits within a small set of pages
				va[ptft_pkg::OFFSET_BITS +: ptft_pkg::PAGE_BITS] =
					ws_base + ptft_pkg::page_t'($urandom_range(ws_size - 1));
			end else if (pick >= 80) begin
				// sequential pages push the victim pointer around
				va[ptft_pkg::OFFSET_BITS +: ptft_pkg::PAGE_BITS] = sweep_page;
				sweep_page++;
			end
			send_address(va, 1'b0, none);
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		while (translation_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Translated %0d addresses: %0d hits, %0d faults, %0d evictions",
			hits + faults_seen, hits, faults_seen, evictions);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
